### src/wgm_pkg.sv
package wgm_pkg;

  // Pattern capacity and derived widths
  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned NPOS        = PATTERN_MAX + 1;
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LVLS        = $clog2(NPOS);

  // Wildcard characters
  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;  // '*'

  // Command codes carried on tuser
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2
  } cmd_e;

  // One transaction presented to the processing logic
  typedef struct packed {
    logic       fire;
    cmd_e       cmd;
    logic [7:0] sym;
    logic       last;
  } wgm_op_t;

  // Current view of the stored pattern
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] bytes;
    logic [PATTERN_MAX-1:0]      star;
    logic [PATTERN_MAX-1:0]      any;
    logic [PATTERN_MAX-1:0]      live;
    logic [LEN_W-1:0]            len;
    logic                        ovf;
  } wgm_pat_t;

  // Star closure as a parallel prefix: a position reaches every later one
  // across an unbroken run of star positions. prop[i] allows i -> i+1.
  function automatic logic [NPOS-1:0] close_stars(input logic [NPOS-1:0]        set,
                                                  input logic [PATTERN_MAX-1:0] prop);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    g = set;
    p = {prop, 1'b0};
    for (int l = 0; l < LVLS; l++) begin
      g = g | (p & (g << (1 << l)));
      p = p & (p << (1 << l));
    end
    return g;
  endfunction

endpackage

### src/wgm_pattern.sv
module wgm_pattern (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wgm_pkg::wgm_op_t                      op_i,
  output wgm_pkg::wgm_pat_t                     pat_o,
  output logic [wgm_pkg::PATTERN_MAX-1:0]       restart_prop_o
);

  logic [wgm_pkg::PATTERN_MAX-1:0][7:0] bytes_q;
  logic [wgm_pkg::PATTERN_MAX-1:0]      star_q;
  logic [wgm_pkg::PATTERN_MAX-1:0]      any_q;
  logic [wgm_pkg::LEN_W-1:0]            len_q, len_d;
  logic                                 ovf_q, ovf_d;
  logic                                 wr_en;
  logic [wgm_pkg::IDX_W-1:0]            wr_idx;
  logic                                 full;
  logic                                 sym_star;
  logic [wgm_pkg::PATTERN_MAX-1:0]      live_q, live_d;

  assign full     = (len_q >= wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX));
  assign wr_idx   = len_q[wgm_pkg::IDX_W-1:0];
  assign sym_star = (op_i.sym == wgm_pkg::SYM_ANY_RUN);
  assign wr_en    = op_i.fire && (op_i.cmd == wgm_pkg::CMD_APPEND) && !full;

  // Length and overflow bookkeeping
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (op_i.fire) begin
      case (op_i.cmd)
        wgm_pkg::CMD_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        wgm_pkg::CMD_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + wgm_pkg::LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  // Pattern storage, classified on write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bytes_q[wr_idx] <= op_i.sym;
      star_q[wr_idx]  <= sym_star;
      any_q[wr_idx]   <= (op_i.sym == wgm_pkg::SYM_ANY_ONE);
    end
  end

  // Occupied positions, now and after this transaction
  always_comb begin
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
      live_q[i] = (wgm_pkg::LEN_W'(i) < len_q);
      live_d[i] = (wgm_pkg::LEN_W'(i) < len_d);
    end
  end

  // Star propagation for the restart closure, including a byte written now
  always_comb begin
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
      if (wr_en && (wr_idx == wgm_pkg::IDX_W'(i))) begin
        restart_prop_o[i] = live_d[i] & sym_star;
      end else begin
        restart_prop_o[i] = live_d[i] & star_q[i];
      end
    end
  end

  assign pat_o.bytes = bytes_q;
  assign pat_o.star  = star_q;
  assign pat_o.any   = any_q;
  assign pat_o.live  = live_q;
  assign pat_o.len   = len_q;
  assign pat_o.ovf   = ovf_q;

endmodule

### src/wgm_match.sv
module wgm_match (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wgm_pkg::wgm_op_t                op_i,
  input  wgm_pkg::wgm_pat_t               pat_i,
  input  logic [wgm_pkg::PATTERN_MAX-1:0] restart_prop_i,
  output logic                            hit_o
);

  logic [wgm_pkg::NPOS-1:0]        active_q, active_d;
  logic [wgm_pkg::NPOS-1:0]        step_set;
  logic [wgm_pkg::NPOS-1:0]        step_closed;
  logic [wgm_pkg::NPOS-1:0]        start_closed;
  logic [wgm_pkg::PATTERN_MAX-1:0] cur_prop;

  assign cur_prop = pat_i.star & pat_i.live;

  // Advance every active position by the name byte
  always_comb begin
    step_set = '0;
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
      if (active_q[i] && pat_i.live[i]) begin
        if (pat_i.star[i]) begin
          step_set[i] = 1'b1;
        end else if (pat_i.any[i] || (pat_i.bytes[i] == op_i.sym)) begin
          step_set[i+1] = 1'b1;
        end
      end
    end
  end

  assign step_closed  = wgm_pkg::close_stars(step_set, cur_prop);
  assign start_closed = wgm_pkg::close_stars(wgm_pkg::NPOS'(1), restart_prop_i);

  // Match when the end of the pattern is reachable
  assign hit_o = (pat_i.len == '0) || step_closed[pat_i.len];

  always_comb begin
    active_d = active_q;
    if (op_i.fire) begin
      case (op_i.cmd)
        wgm_pkg::CMD_CLEAR,
        wgm_pkg::CMD_APPEND: begin
          active_d = start_closed;
        end
        wgm_pkg::CMD_NAME: begin
          active_d = op_i.last ? start_closed : step_closed;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= wgm_pkg::NPOS'(1);
    end else begin
      active_q <= active_d;
    end
  end

endmodule

### src/wildcard_glob_matcher_core.sv
// Path: a name byte marked last gives its result via the input register and the
// result register. Throughput: one transaction per cycle unless a last name byte
// meets a blocked result slot; the star closure over all pattern positions is a
// parallel prefix, so no step iterates.
// Reset (rst_ni, async, active low): empty pattern, overflow clear, no result
// pending; pattern bytes themselves are not cleared.
module wildcard_glob_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  logic              in_vld_q;
  wgm_pkg::cmd_e     in_cmd_q;
  logic [7:0]        in_sym_q;
  logic              in_last_q;
  logic              out_vld_q;
  logic              out_hit_q;
  logic              out_ovf_q;
  logic              need_out;
  logic              stall;
  logic              fire;
  logic              hit;
  wgm_pkg::wgm_op_t  op;
  wgm_pkg::wgm_pat_t pat;
  logic [wgm_pkg::PATTERN_MAX-1:0] restart_prop;

  // Handshake: stall only when a result must go out and the slot is blocked
  assign need_out      = (in_cmd_q == wgm_pkg::CMD_NAME) && in_last_q;
  assign stall         = in_vld_q && need_out && out_vld_q && !m_axis_tready;
  assign fire          = in_vld_q && !stall;
  assign s_axis_tready = !stall;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= wgm_pkg::cmd_e'(s_axis_tuser);
      in_sym_q  <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign op.fire = fire;
  assign op.cmd  = in_cmd_q;
  assign op.sym  = in_sym_q;
  assign op.last = in_last_q;

  wgm_pattern u_pattern (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .pat_o          (pat),
    .restart_prop_o (restart_prop)
  );

  wgm_match u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .pat_i          (pat),
    .restart_prop_i (restart_prop),
    .hit_o          (hit)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && need_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && need_out) begin
      out_hit_q <= hit;
      out_ovf_q <= pat.ovf;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_hit_q};

`ifndef SYNTHESIS
  // A new result only follows a final name byte taken the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire && need_out))
    else $error("result without a final name byte");

  // Stored length never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat.len <= wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX))
    else $error("pattern length beyond capacity");

  // Clear empties the pattern and drops the overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_cmd_q == wgm_pkg::CMD_CLEAR)) |=> (pat.len == '0) && !pat.ovf)
    else $error("clear did not reset pattern state");
`endif

endmodule

### verif/tb_wildcard_glob_matcher_core.sv
module tb_wildcard_glob_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  // tuser value that carries no command; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned ITEM_TARGET  = 1950;
  localparam int unsigned CALM_AFTER   = 1700;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Result layout, lowest bit first: matched, pattern_overflow, zero fill
  typedef struct packed {
    logic [5:0] pad;
    logic       ovf;
    logic       matched;
  } verdict_t;

  localparam verdict_t NO_CHECK   = '0;
  localparam verdict_t HIT_CLEAN  = '{pad: '0, ovf: 1'b0, matched: 1'b1};
  localparam verdict_t MISS_CLEAN = '{pad: '0, ovf: 1'b0, matched: 1'b0};
  localparam verdict_t HIT_OVF    = '{pad: '0, ovf: 1'b1, matched: 1'b1};

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic        last;
    int unsigned rep;
    bit          chk;
    verdict_t    typed;
  } dir_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [7:0] symbol
  logic [1:0] s_axis_tuser  = wgm_pkg::CMD_CLEAR;  // [1:0] command
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;  // [0] matched, [1] pattern_overflow, [7:2] zero

  wildcard_glob_matcher_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Directed stimulus; typed results only where they are obvious
  dir_row_t dir_rows [24] = '{
    '{wgm_pkg::CMD_NAME,   8'h61, 1'b1, 1, 1'b1, HIT_CLEAN},  // empty pattern
    '{wgm_pkg::CMD_NAME,   8'hFF, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h00, 1'b1, 1, 1'b1, HIT_CLEAN},
    '{CMD_UNUSED,          8'hFF, 1'b1, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_CLEAR,  8'hFF, 1'b1, 1, 1'b0, NO_CHECK},   // tlast ignored
    '{wgm_pkg::CMD_APPEND, 8'h61, 1'b1, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_APPEND, wgm_pkg::SYM_ANY_ONE, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_APPEND, wgm_pkg::SYM_ANY_RUN, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h61, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h78, 1'b1, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h62, 1'b1, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h61, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_APPEND, 8'h63, 1'b0, 1, 1'b0, NO_CHECK},   // edit mid-name
    '{wgm_pkg::CMD_NAME,   8'h61, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h62, 1'b0, 1, 1'b0, NO_CHECK},
    '{CMD_UNUSED,          8'h00, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h63, 1'b1, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_CLEAR,  8'h00, 1'b0, 1, 1'b0, NO_CHECK},
    // one star more than fits, so one is dropped
    '{wgm_pkg::CMD_APPEND, wgm_pkg::SYM_ANY_RUN, 1'b0, wgm_pkg::PATTERN_MAX + 1,
      1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'h00, 1'b1, 1, 1'b1, HIT_OVF},
    '{wgm_pkg::CMD_CLEAR,  8'h00, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_APPEND, 8'hFF, 1'b0, 1, 1'b0, NO_CHECK},
    '{wgm_pkg::CMD_NAME,   8'hFF, 1'b1, 1, 1'b1, HIT_CLEAN},
    '{wgm_pkg::CMD_NAME,   8'h00, 1'b1, 1, 1'b1, MISS_CLEAN}
  };

  // Shadow of the matcher state
  logic [7:0]               pat_bytes [wgm_pkg::PATTERN_MAX];
  int unsigned              pat_len   = 0;
  logic                     pat_ovf   = 1'b0;
  logic [wgm_pkg::NPOS-1:0] reach     = wgm_pkg::NPOS'(1);

  verdict_t verdict_q [$];
  logic [7:0] gen_pat [$];  // pattern as the generator knows it

  bit          calm        = 1'b0;
  int unsigned n_items     = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_results   = 0;
  int unsigned n_hits      = 0;
  int unsigned n_ovf       = 0;
  int unsigned n_errors    = 0;
  int unsigned quiet       = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Positions reachable across stars, lowest first
  function automatic logic [wgm_pkg::NPOS-1:0] star_closure(
      input logic [wgm_pkg::NPOS-1:0] s);
    for (int i = 0; i < pat_len; i++) begin
      if (s[i] && pat_bytes[i] == wgm_pkg::SYM_ANY_RUN) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  // Advance the shadow state by one transaction
  task automatic predict_txn(input logic [1:0] cmd, input logic [7:0] sym,
                             input logic last, output bit emits, output verdict_t v);
    logic [wgm_pkg::NPOS-1:0] nxt;
    emits = 1'b0;
    v     = '0;
    case (cmd)
      wgm_pkg::CMD_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        reach   = star_closure(wgm_pkg::NPOS'(1));
      end
      wgm_pkg::CMD_APPEND: begin
        if (pat_len < wgm_pkg::PATTERN_MAX) begin
          pat_bytes[pat_len] = sym;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        reach = star_closure(wgm_pkg::NPOS'(1));
      end
      wgm_pkg::CMD_NAME: begin
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (reach[i]) begin
            if (pat_bytes[i] == wgm_pkg::SYM_ANY_RUN) nxt[i] = 1'b1;
            else if (pat_bytes[i] == wgm_pkg::SYM_ANY_ONE || pat_bytes[i] == sym)
              nxt[i+1] = 1'b1;
          end
        end
        reach = star_closure(nxt);
        if (last) begin
          emits     = 1'b1;
          v.matched = (pat_len == 0) ? 1'b1 : reach[pat_len];
          v.ovf     = pat_ovf;
          reach     = star_closure(wgm_pkg::NPOS'(1));
        end
      end
      default: ;
    endcase
  endtask

  // Offer one transaction, wait for it, and record what it should produce
  task automatic send_txn(input logic [1:0] cmd, input logic [7:0] sym, input logic last,
                          input bit chk, input verdict_t typed);
    bit       emits;
    verdict_t v;
    if (!calm && $urandom_range(0, 11) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_txn(cmd, sym, last, emits, v);
    if (emits) verdict_q.insert(verdict_q.size(), chk ? typed : v);
    if (cmd != CMD_UNUSED) n_items++;
    n_accepted++;
  endtask

  function automatic logic [7:0] name_byte();
    int unsigned r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 85) return 8'($urandom_range(0, 255));
    return r[0] ? wgm_pkg::SYM_ANY_ONE : wgm_pkg::SYM_ANY_RUN;
  endfunction

  function automatic logic [7:0] pattern_byte();
    int unsigned r = $urandom_range(0, 99);
    if (r < 40) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 60) return wgm_pkg::SYM_ANY_ONE;
    if (r < 85) return wgm_pkg::SYM_ANY_RUN;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic clear_pattern();
    gen_pat.delete();
    send_txn(wgm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             1'b0, NO_CHECK);
  endtask

  task automatic add_pattern_byte(input logic [7:0] b);
    if (gen_pat.size() < wgm_pkg::PATTERN_MAX) gen_pat.insert(gen_pat.size(), b);
    send_txn(wgm_pkg::CMD_APPEND, b, 1'($urandom_range(0, 1)), 1'b0, NO_CHECK);
  endtask

  // Name shaped after the pattern, sometimes mutated or interrupted
  task automatic send_name();
    logic [7:0]  nm [$];
    int unsigned j;
    foreach (gen_pat[i]) begin
      if (gen_pat[i] == wgm_pkg::SYM_ANY_RUN)
        repeat ($urandom_range(0, 3)) nm.insert(nm.size(), name_byte());
      else if (gen_pat[i] == wgm_pkg::SYM_ANY_ONE) nm.insert(nm.size(), name_byte());
      else nm.insert(nm.size(), gen_pat[i]);
    end
    if ($urandom_range(0, 2) == 0 && nm.size() > 0) begin
      j = $urandom_range(0, nm.size() - 1);
      case ($urandom_range(0, 2))
        0: nm[j] = name_byte();
        1: nm.delete(j);
        default: nm.insert(j, name_byte());
      endcase
    end
    if (nm.size() == 0) nm.insert(0, name_byte());
    foreach (nm[i]) begin
      if ($urandom_range(0, 49) == 0) begin
        add_pattern_byte(pattern_byte());
      end else if ($urandom_range(0, 49) == 0) begin
        send_txn(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'b0, NO_CHECK);
      end
      send_txn(wgm_pkg::CMD_NAME, nm[i], logic'(i == nm.size() - 1), 1'b0, NO_CHECK);
    end
  endtask

  // Stray transactions of any kind
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      case (2'($urandom_range(0, 3)))
        wgm_pkg::CMD_CLEAR:  clear_pattern();
        wgm_pkg::CMD_APPEND: add_pattern_byte(8'($urandom_range(0, 255)));
        wgm_pkg::CMD_NAME:   send_txn(wgm_pkg::CMD_NAME, 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), 1'b0, NO_CHECK);
        default:             send_txn(CMD_UNUSED, 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), 1'b0, NO_CHECK);
      endcase
    end
  endtask

  // Result side: random back-pressure plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && !calm && n_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk_i);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata);
      if (verdict_q.size() == 0) begin
        $error("unexpected result transaction: tdata %02h", m_axis_tdata);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        n_results++;
        if (got.matched) n_hits++;
        if (got.ovf) n_ovf++;
        if (got.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, got.matched);
          n_errors++;
        end
        if (got.ovf !== want.ovf) begin
          $error("pattern_overflow: expected %0d, got %0d", want.ovf, got.ovf);
          n_errors++;
        end
        if (got.pad !== want.pad) begin
          $error("tdata fill: expected %0h, got %0h", want.pad, got.pad);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d results still outstanding", verdict_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Main stimulus
  initial begin
    int unsigned r;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].rep) begin
        send_txn(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].last,
                 dir_rows[i].chk, dir_rows[i].typed);
      end
    end
    gen_pat.insert(gen_pat.size(), 8'hFF);

    while (n_items < ITEM_TARGET) begin
      if (n_items >= CALM_AFTER) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_noise();
      end else begin
        if (r < 92) clear_pattern();
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6))
          add_pattern_byte(pattern_byte());
        repeat ($urandom_range(1, 4)) send_name();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions in (%0d commands), %0d results checked",
             n_accepted, n_items, n_results);
    $display("%0d names matched, %0d reported pattern overflow", n_hits, n_ovf);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
